// ----- rtl/rxrb_pkg.sv -----
// ---------------------------------------------------------------------------
// rxrb_pkg: shared definitions for the rotate-xor bounded random unit
// Word width, generator constants, command codes and the divider interface.
// ---------------------------------------------------------------------------
package rxrb_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);

    // Generator constants
    localparam logic [WORD_W-1:0] XOR_KEY = 32'h1234_567F;
    localparam int ROT_A = 7;
    localparam int ROT_B = 3;

    // Cap on draws for one bounded request
    localparam int MAX_TRIES = 256;
    localparam int TRY_W     = $clog2(MAX_TRIES);

    // Command codes
    localparam logic [1:0] CMD_RAW     = 2'd0;
    localparam logic [1:0] CMD_BOUNDED = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Request to the serial remainder unit
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } rxrb_mod_req_t;

    // Status from the serial remainder unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] rem;
    } rxrb_mod_sts_t;

    // Rotate right by a constant amount between 1 and WORD_W-1
    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

// ----- rtl/rotate_xor_random_with_bound_unit.sv -----
// Raw draw, load, unused command and bounded draw with a limit below 2 or a power
// of two register the result on acceptance and then go to the result state.
// Other limits run the bit-serial remainder unit once for the cap, draw up to 256
// times (almost always once), then run the remainder unit once more for the value.
// One request in flight; the next is taken as soon as the result is registered.
// Reset (rst_n low, asynchronous) clears both generator words and all control state.
// ---------------------------------------------------------------------------
// rotate_xor_random_with_bound_unit: rotate-xor random generator, bounded draws
// Two-word generator advanced once per draw; bounded draws use rejection
// against a cap and a serial remainder unit for the modulo.
// ---------------------------------------------------------------------------
module rotate_xor_random_with_bound_unit
    import rxrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [WORD_W-1:0] limit,
    input  logic [WORD_W-1:0] seed_first,
    input  logic [WORD_W-1:0] seed_second,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MODCAP = 3'd1;
    localparam logic [2:0] ST_DRAW   = 3'd2;
    localparam logic [2:0] ST_MODVAL = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [WORD_W-1:0] word_first_reg, word_first_next;
    logic [WORD_W-1:0] word_second_reg, word_second_next;
    logic [TRY_W-1:0]  tries_reg, tries_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] cap_reg, cap_next;
    logic [WORD_W-1:0] limit_reg, limit_next;
    logic [WORD_W-1:0] adv_first;
    logic [WORD_W-1:0] adv_second;
    logic              in_accept;
    logic              lim_small;
    logic              lim_pow2;
    rxrb_mod_req_t     mod_req;
    rxrb_mod_sts_t     mod_sts;

    // Generator advance
    assign adv_first  = word_first_reg + rotr(word_second_reg ^ XOR_KEY, ROT_A);
    assign adv_second = rotr(word_first_reg, ROT_B);

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign lim_small = (limit < WORD_W'(2));
    assign lim_pow2  = ((limit & (limit - 1'b1)) == '0);

    rxrb_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .sts   (mod_sts)
    );

    always_comb
    begin
        state_next       = state_reg;
        word_first_next  = word_first_reg;
        word_second_next = word_second_reg;
        tries_next       = tries_reg;
        res_next         = res_reg;
        cap_next         = cap_reg;
        limit_next       = limit_reg;
        out_valid_next   = out_valid_reg;
        value_next       = value_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = adv_second;
        mod_req.divisor  = limit_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_next   = '0;
                    limit_next = limit;
                    state_next = ST_RESULT;
                    unique case (cmd)
                        CMD_RAW:
                        begin
                            word_first_next  = adv_first;
                            word_second_next = adv_second;
                            res_next         = adv_second;
                        end
                        CMD_BOUNDED:
                        begin
                            priority if (lim_small)
                            begin
                                res_next = '0;
                            end
                            else if (lim_pow2)
                            begin
                                word_first_next  = adv_first;
                                word_second_next = adv_second;
                                res_next         = adv_second & (limit - 1'b1);
                            end
                            else
                            begin
                                // Find the rejection cap first
                                mod_req.start    = 1'b1;
                                mod_req.dividend = '1;
                                mod_req.divisor  = limit;
                                state_next       = ST_MODCAP;
                            end
                        end
                        CMD_LOAD:
                        begin
                            word_first_next  = seed_first;
                            word_second_next = seed_second;
                        end
                        CMD_UNUSED:
                        begin
                            res_next = '0;
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ST_MODCAP:
            begin
                if (mod_sts.done)
                begin
                    cap_next   = ~mod_sts.rem - 1'b1;
                    tries_next = '0;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                // Advance once a cycle until a draw falls within the cap or MAX_TRIES draws are used
                word_first_next  = adv_first;
                word_second_next = adv_second;
                tries_next       = tries_reg + 1'b1;
                if (!(adv_second > cap_reg) || tries_reg == TRY_W'(MAX_TRIES - 1))
                begin
                    mod_req.start = 1'b1;
                    state_next    = ST_MODVAL;
                end
            end
            ST_MODVAL:
            begin
                if (mod_sts.done)
                begin
                    res_next   = mod_sts.rem;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            word_first_reg  <= '0;
            word_second_reg <= '0;
            tries_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            word_first_reg  <= word_first_next;
            word_second_reg <= word_second_next;
            tries_reg       <= tries_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        cap_reg   <= cap_next;
        limit_reg <= limit_next;
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // The divider only runs while a modulo state waits on it
    a_mod_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mod_sts.busy |-> (state_reg == ST_MODCAP || state_reg == ST_MODVAL))
        else $error("divider busy outside modulo states");

    // A load request sets both words on the next edge
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_LOAD) |=>
            (word_first_reg == $past(seed_first) && word_second_reg == $past(seed_second)))
        else $error("load did not take effect");

    // The generator does not move while idle
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !in_accept) |=>
            ($stable(word_first_reg) && $stable(word_second_reg)))
        else $error("generator moved while idle");

    // A result is only registered on leaving the result state
    a_result_path: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("result appeared outside the result state");

endmodule

// ----- rtl/rxrb_mod.sv -----
// ---------------------------------------------------------------------------
// rxrb_mod: bit-serial remainder unit
// Restoring division, one dividend bit shifted in per cycle.
// ---------------------------------------------------------------------------
module rxrb_mod
    import rxrb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rxrb_mod_req_t req,
    output rxrb_mod_sts_t sts
);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;

    // Shift in the next dividend bit and try a subtract
    assign rem_sh = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, div_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dvd_next = req.dividend;
            div_next = req.divisor;
        end
        else if (run_reg)
        begin
            rem_next = diff[WORD_W] ? rem_sh[WORD_W-1:0] : diff[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign sts.rem  = rem_reg;

    // The remainder is reduced below a nonzero divisor when it is reported
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("remainder not reduced");

    // A finished division leaves the unit idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("done while running");

    // Every division starts from a zero count
    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(run_reg) |-> (cnt_reg == '0))
        else $error("division started mid-count");

endmodule
